[design/wwls_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwls_pkg: shared types and constants for the whole-word line search
// Default sizes, item kind codes, register indexes and the result record.
// ----------------------------------------------------------------------------
package wwls_pkg;

  localparam int unsigned PATTERN_MAX_DEF = 256;
  localparam int unsigned CHUNK_LEN_DEF   = 255;
  localparam int unsigned LINE_BITS_DEF   = 24;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PLEN_W     = 9;
  localparam int unsigned TAG_W      = 8;
  localparam int unsigned PIDX_IN_W  = 8;
  localparam int unsigned FUNC_W     = 2;
  localparam int unsigned OUT_LINE_W = 24;
  localparam int unsigned OUT_COL_W  = 8;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 9;

  localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0a;

  localparam logic [PLEN_W-1:0] PLEN_RST = 9'd1;
  localparam logic [TAG_W-1:0]  TAG_RST  = 8'd1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD = 2'd0,
    FUNC_TEXT = 2'd1,
    FUNC_EOF  = 2'd2
  } func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_LENGTH = 1'b0,
    CFG_FILE_TAG       = 1'b1
  } cfg_reg_e;

  // packed low to high: file, line, column
  typedef struct packed {
    logic [OUT_COL_W-1:0]  column;
    logic [OUT_LINE_W-1:0] line;
    logic [TAG_W-1:0]      file;
  } res_t;

endpackage

[design/wwls_pat_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwls_pat_mem: pattern byte memory
// One write port and one registered read port; a write to the address being
// read is forwarded so the read data always tracks the current entry.
// ----------------------------------------------------------------------------
module wwls_pat_mem #(
  parameter int unsigned PATTERN_MAX = wwls_pkg::PATTERN_MAX_DEF
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [$clog2(PATTERN_MAX)-1:0] waddr_i,
  input  logic [wwls_pkg::BYTE_W-1:0]    wdata_i,
  input  logic [$clog2(PATTERN_MAX)-1:0] raddr_i,
  output logic [wwls_pkg::BYTE_W-1:0]    rdata_o
);
  import wwls_pkg::*;

  logic [BYTE_W-1:0] mem [PATTERN_MAX];
  logic [BYTE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/wwls_scan.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wwls_scan: word match and line tracking
// Holds the scan state, compares one byte per item against the pattern and
// produces at most one hit record per item.
// ----------------------------------------------------------------------------
module wwls_scan #(
  parameter int unsigned PATTERN_MAX = wwls_pkg::PATTERN_MAX_DEF,
  parameter int unsigned CHUNK_LEN   = wwls_pkg::CHUNK_LEN_DEF,
  parameter int unsigned LINE_BITS   = wwls_pkg::LINE_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           step_i,
  input  wwls_pkg::func_e                func_i,
  input  logic [wwls_pkg::PIDX_IN_W-1:0] pattern_index_i,
  input  logic [wwls_pkg::BYTE_W-1:0]    data_byte_i,
  input  logic [wwls_pkg::PLEN_W-1:0]    pattern_length_i,
  input  logic [wwls_pkg::TAG_W-1:0]     file_tag_i,
  input  logic [wwls_pkg::BYTE_W-1:0]    pat_byte_i,
  output logic [$clog2(PATTERN_MAX)-1:0] pat_raddr_o,
  output logic                           pat_we_o,
  output logic [$clog2(PATTERN_MAX)-1:0] pat_waddr_o,
  output logic                           hit_o,
  output wwls_pkg::res_t                 res_o
);
  import wwls_pkg::*;

  localparam int unsigned PIDX_W = $clog2(PATTERN_MAX);
  localparam int unsigned MC_W   = $clog2(PATTERN_MAX + 1);
  localparam int unsigned COL_W  = $clog2(CHUNK_LEN + 1);
  localparam int unsigned DW0    = (COL_W > MC_W) ? COL_W : MC_W;
  localparam int unsigned DW     = (DW0 > OUT_COL_W) ? DW0 : OUT_COL_W;

  logic [MC_W-1:0]      mc_q, mc_d;
  logic                 cand_q, cand_d;
  logic [COL_W-1:0]     col_q, col_d;
  logic [LINE_BITS-1:0] line_q, line_d;

  logic [MC_W-1:0]  m_len;
  logic [COL_W-1:0] col_inc;
  logic [DW-1:0]    hcol;
  logic             is_sp, is_nl, hit;

  // length in use, clamped to the store depth
  always_comb begin
    if (32'(pattern_length_i) > PATTERN_MAX) begin
      m_len = MC_W'(PATTERN_MAX);
    end else begin
      m_len = MC_W'(pattern_length_i);
    end
  end

  assign col_inc = col_q + COL_W'(1);
  assign is_sp   = (data_byte_i == CH_SPACE);
  assign is_nl   = (data_byte_i == CH_NEWLINE);

  always_comb begin
    mc_d     = mc_q;
    cand_d   = cand_q;
    col_d    = col_q;
    line_d   = line_q;
    hit      = 1'b0;
    hcol     = '0;
    pat_we_o = 1'b0;
    if (step_i) begin
      case (func_i)
        FUNC_LOAD: begin
          pat_we_o = (32'(pattern_index_i) < PATTERN_MAX);
        end
        FUNC_EOF: begin
          if ((col_q != '0) && cand_q && (mc_q != '0) && (mc_q == m_len)) begin
            hit  = 1'b1;
            hcol = DW'(col_q) - DW'(m_len);
          end
          line_d = '0;
          col_d  = '0;
          cand_d = 1'b1;
          mc_d   = '0;
        end
        FUNC_TEXT: begin
          if (cand_q) begin
            if ((mc_q < m_len) && (data_byte_i == pat_byte_i)) begin
              mc_d = mc_q + MC_W'(1);
            end else begin
              if ((mc_q == m_len) && (is_sp || is_nl)) begin
                hit  = 1'b1;
                hcol = DW'(col_q) - DW'(m_len);
              end
              mc_d   = '0;
              cand_d = is_sp;
            end
          end else if (is_sp) begin
            cand_d = 1'b1;
            mc_d   = '0;
          end
          // end of line: newline or chunk full
          if (is_nl || (col_inc >= COL_W'(CHUNK_LEN))) begin
            if (!hit && cand_d && (mc_d != '0) && (mc_d == m_len)) begin
              hit  = 1'b1;
              hcol = DW'(col_inc) - DW'(m_len);
            end
            if (line_q != '1) begin
              line_d = line_q + LINE_BITS'(1);
            end
            col_d  = '0;
            cand_d = 1'b1;
            mc_d   = '0;
          end else begin
            col_d = col_inc;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mc_q   <= '0;
      cand_q <= 1'b1;
      col_q  <= '0;
      line_q <= '0;
    end else begin
      mc_q   <= mc_d;
      cand_q <= cand_d;
      col_q  <= col_d;
      line_q <= line_d;
    end
  end

  // read address follows the next compare position
  assign pat_raddr_o = mc_d[PIDX_W-1:0];
  assign pat_waddr_o = PIDX_W'(pattern_index_i);

  assign hit_o       = hit;
  assign res_o.file   = file_tag_i;
  assign res_o.line   = OUT_LINE_W'(line_q);
  assign res_o.column = hcol[OUT_COL_W-1:0];

endmodule

[design/whole_word_line_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// whole_word_line_search: whole-word pattern search over a text stream
// Top level: configuration registers, item register, result register.
// ----------------------------------------------------------------------------
// The block takes one item per clock cycle while the result register is not held
// by back-pressure; a hit passes through the item register and then the result
// register. The rate is set by the single compare of each text byte against
// the pattern memory, whose registered read port is addressed with the next
// match position so the byte for the following item is always ready. Load
// pattern bytes (tuser kind 0) before scanning; entries never loaded read as
// unknown. There is no clearing pass after reset. Write the registers only
// while no item is in flight.
// ----------------------------------------------------------------------------
module whole_word_line_search #(
  parameter int unsigned PATTERN_MAX = wwls_pkg::PATTERN_MAX_DEF,
  parameter int unsigned CHUNK_LEN   = wwls_pkg::CHUNK_LEN_DEF,
  parameter int unsigned LINE_BITS   = wwls_pkg::LINE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [wwls_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wwls_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,  // pattern_index, data_byte
  input  logic [1:0]                      s_axis_tuser,  // func
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [39:0]                     m_axis_tdata   // match_file, match_line, match_column
);
  import wwls_pkg::*;

  localparam int unsigned PIDX_W = $clog2(PATTERN_MAX);

  logic [PLEN_W-1:0] pattern_length_q;
  logic [TAG_W-1:0]  file_tag_q;

  logic                 in_v_q;
  func_e                func_q;
  logic [PIDX_IN_W-1:0] pattern_index_q;
  logic [BYTE_W-1:0]    data_byte_q;

  logic out_v_q;
  res_t out_q;

  logic              proc_ok, step, s_acc, hit;
  res_t              res;
  logic [BYTE_W-1:0] pat_byte;
  logic [PIDX_W-1:0] pat_raddr, pat_waddr;
  logic              pat_we;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_length_q <= PLEN_RST;
      file_tag_q       <= TAG_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_PATTERN_LENGTH: pattern_length_q <= cfg_data_i[PLEN_W-1:0];
        CFG_FILE_TAG:       file_tag_q       <= cfg_data_i[TAG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign proc_ok       = !out_v_q || m_axis_tready;
  assign step          = in_v_q && proc_ok;
  assign s_axis_tready = !in_v_q || proc_ok;
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  // item register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_acc) begin
      in_v_q <= 1'b1;
    end else if (step) begin
      in_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      func_q          <= func_e'(s_axis_tuser);
      pattern_index_q <= s_axis_tdata[7:0];
      data_byte_q     <= s_axis_tdata[15:8];
    end
  end

  wwls_pat_mem #(
    .PATTERN_MAX(PATTERN_MAX)
  ) u_pat_mem (
    .clk_i  (clk_i),
    .we_i   (pat_we),
    .waddr_i(pat_waddr),
    .wdata_i(data_byte_q),
    .raddr_i(pat_raddr),
    .rdata_o(pat_byte)
  );

  wwls_scan #(
    .PATTERN_MAX(PATTERN_MAX),
    .CHUNK_LEN  (CHUNK_LEN),
    .LINE_BITS  (LINE_BITS)
  ) u_scan (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .func_i          (func_q),
    .pattern_index_i (pattern_index_q),
    .data_byte_i     (data_byte_q),
    .pattern_length_i(pattern_length_q),
    .file_tag_i      (file_tag_q),
    .pat_byte_i      (pat_byte),
    .pat_raddr_o     (pat_raddr),
    .pat_we_o        (pat_we),
    .pat_waddr_o     (pat_waddr),
    .hit_o           (hit),
    .res_o           (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (step && hit) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && hit) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

`ifndef NO_ASSERTIONS
  // a result only appears after an item left the item register
  a_out_from_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(in_v_q))
    else $error("result without a processed item");

  // a stalled item stays put until it can be processed
  a_item_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_v_q && !proc_ok) |=> (in_v_q && $stable(data_byte_q) && $stable(func_q)))
    else $error("item register changed while stalled");

  // the result register is not overwritten while waiting
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !m_axis_tready) |=> (out_v_q && $stable(out_q)))
    else $error("pending result overwritten");
`endif

endmodule
